>>> sv/paper_tape_reader_punch_ctrl_defines.svh
// Assertion macros for the paper-tape reader/punch controller.
`ifndef PAPER_TAPE_READER_PUNCH_CTRL_DEFINES_SVH
`define PAPER_TAPE_READER_PUNCH_CTRL_DEFINES_SVH

// same-cycle implication, checked out of reset
`define PTRPC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define PTRPC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/ptrpc_pkg.sv
// Types and constants shared by the paper-tape reader/punch controller.
`timescale 1ns / 1ps

package ptrpc_pkg;

    localparam int CMD_W          = 2;
    localparam int OP_W           = 3;
    localparam int ACC_W          = 12;
    localparam int BYTE_W         = 8;
    localparam int DELAY_W        = 16;
    localparam int TIMER_MAX_BITS = 32;
    localparam int APB_DATA_W     = 32;
    localparam int APB_ADDR_W     = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_READER = 2'd0,
        CMD_PUNCH  = 2'd1,
        CMD_TICK   = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    // device operation codes (low instruction bits)
    localparam logic [OP_W-1:0] OP_IRQ        = 3'd0;
    localparam logic [OP_W-1:0] OP_SKIP       = 3'd1;
    localparam logic [OP_W-1:0] OP_CLEAR      = 3'd2;
    localparam logic [OP_W-1:0] OP_START      = 3'd4;
    localparam logic [OP_W-1:0] OP_CLEAR_START = 3'd6;

    // register indexes
    localparam logic REG_READER_DELAY = 1'b0;
    localparam logic REG_PUNCH_DELAY  = 1'b1;

    localparam logic [DELAY_W-1:0] READER_DELAY_RST = 16'd3333;
    localparam logic [DELAY_W-1:0] PUNCH_DELAY_RST  = 16'd20000;

    localparam logic [BYTE_W-1:0] ALL_HOLES = 8'hFF;

    typedef struct packed {
        logic [DELAY_W-1:0] rdr_ticks;
        logic [DELAY_W-1:0] pun_ticks;
    } t_cfg;

endpackage

>>> sv/ptrpc_apb_regs.sv
// APB register file holding the reader and punch delay settings.
`timescale 1ns / 1ps

module ptrpc_apb_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ptrpc_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [ptrpc_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [ptrpc_pkg::APB_DATA_W-1:0]  prdata,
    output logic                              pready,
    output ptrpc_pkg::t_cfg                   o_cfg
);
    import ptrpc_pkg::*;

    logic [DELAY_W-1:0] r_rdr_ticks;
    logic [DELAY_W-1:0] r_pun_ticks;
    logic               wr_en;
    logic               reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_sel = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rdr_ticks <= READER_DELAY_RST;
            r_pun_ticks <= PUNCH_DELAY_RST;
        end else if (wr_en) begin
            case (reg_sel)
                REG_READER_DELAY: r_rdr_ticks <= pwdata[DELAY_W-1:0];
                REG_PUNCH_DELAY:  r_pun_ticks <= pwdata[DELAY_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_READER_DELAY: prdata = {(APB_DATA_W-DELAY_W)'(0), r_rdr_ticks};
            REG_PUNCH_DELAY:  prdata = {(APB_DATA_W-DELAY_W)'(0), r_pun_ticks};
            default:          prdata = '0;
        endcase
    end

    assign o_cfg.rdr_ticks = r_rdr_ticks;
    assign o_cfg.pun_ticks = r_pun_ticks;

endmodule

>>> sv/paper_tape_reader_punch_ctrl.sv
// Top level of the paper-tape reader and punch controller.
//
//   channel   direction  handshake                  payload
//   in        to block   i_in_valid / o_in_stall    command, op bits, acc, tape byte/present
//   out       from block o_out_valid / i_out_stall  skip, OR byte, irq, punch, tape taken
//   config    to block   APB psel/penable/pwrite    reader and punch delays
//
// One beat per cycle while the result is not stalled; each beat's result is registered on acceptance.
// All flag and timer updates are computed combinationally from the state registers.
// Reset (synchronous, active low) clears ready flags, data, timers and the result valid, and sets irq enable.
// A stalled result holds the input stalled; a draining result lets a new beat in.
`timescale 1ns / 1ps
`include "paper_tape_reader_punch_ctrl_defines.svh"

module paper_tape_reader_punch_ctrl #(
    parameter int TIMER_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [ptrpc_pkg::CMD_W-1:0]       i_command,
    input  logic [ptrpc_pkg::OP_W-1:0]        i_op_bits,
    input  logic [ptrpc_pkg::ACC_W-1:0]       i_acc_value,
    input  logic [ptrpc_pkg::BYTE_W-1:0]      i_tape_byte,
    input  logic                              i_tape_present,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_skip,
    output logic [ptrpc_pkg::BYTE_W-1:0]      o_acc_or_value,
    output logic                              o_irq_request,
    output logic                              o_punch_valid,
    output logic [ptrpc_pkg::BYTE_W-1:0]      o_punch_byte,
    output logic                              o_tape_taken,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ptrpc_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [ptrpc_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [ptrpc_pkg::APB_DATA_W-1:0]  prdata,
    output logic                              pready
);
    import ptrpc_pkg::*;

    t_cfg cfg;

    ptrpc_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // device state
    logic                  r_rdr_ready, n_rdr_ready;
    logic                  r_pun_ready, n_pun_ready;
    logic                  r_irq_en,    n_irq_en;
    logic [BYTE_W-1:0]     r_rdr_data,  n_rdr_data;
    logic [BYTE_W-1:0]     r_pun_data,  n_pun_data;
    logic [TIMER_BITS-1:0] r_rdr_rem,   n_rdr_rem;
    logic [TIMER_BITS-1:0] r_pun_rem,   n_pun_rem;

    // result register
    logic                  r_out_valid;
    logic                  r_skip,   n_skip;
    logic [BYTE_W-1:0]     r_orv,    n_orv;
    logic                  r_irq,    n_irq;
    logic                  r_pvalid, n_pvalid;
    logic [BYTE_W-1:0]     r_pbyte,  n_pbyte;
    logic                  r_taken,  n_taken;

    logic                      in_acc;
    logic [TIMER_MAX_BITS-1:0] rdr_ext, pun_ext;
    logic [TIMER_BITS-1:0]     rdr_load, pun_load;

    assign o_in_stall = r_out_valid & i_out_stall;
    assign in_acc     = i_in_valid & ~o_in_stall;

    // zero delay after masking counts as one tick
    assign rdr_ext  = {(TIMER_MAX_BITS-DELAY_W)'(0), cfg.rdr_ticks};
    assign pun_ext  = {(TIMER_MAX_BITS-DELAY_W)'(0), cfg.pun_ticks};
    assign rdr_load = (rdr_ext[TIMER_BITS-1:0] == '0) ? TIMER_BITS'(1)
                                                      : rdr_ext[TIMER_BITS-1:0];
    assign pun_load = (pun_ext[TIMER_BITS-1:0] == '0) ? TIMER_BITS'(1)
                                                      : pun_ext[TIMER_BITS-1:0];

    always_comb begin
        n_rdr_ready = r_rdr_ready;
        n_pun_ready = r_pun_ready;
        n_irq_en    = r_irq_en;
        n_rdr_data  = r_rdr_data;
        n_pun_data  = r_pun_data;
        n_rdr_rem   = r_rdr_rem;
        n_pun_rem   = r_pun_rem;
        n_skip      = 1'b0;
        n_orv       = '0;
        n_pvalid    = 1'b0;
        n_pbyte     = '0;
        n_taken     = 1'b0;
        case (t_cmd'(i_command))
            CMD_READER: begin
                case (i_op_bits)
                    OP_IRQ:  n_irq_en = 1'b1;
                    OP_SKIP: n_skip   = r_rdr_ready;
                    OP_CLEAR: begin
                        n_orv       = r_rdr_data;
                        n_rdr_ready = 1'b0;
                    end
                    OP_START: begin
                        n_rdr_ready = 1'b0;
                        n_rdr_rem   = rdr_load;
                    end
                    OP_CLEAR_START: begin
                        n_orv       = r_rdr_data;
                        n_rdr_ready = 1'b0;
                        n_rdr_rem   = rdr_load;
                    end
                    default: ;
                endcase
            end
            CMD_PUNCH: begin
                case (i_op_bits)
                    OP_IRQ:   n_irq_en    = 1'b0;
                    OP_SKIP:  n_skip      = r_pun_ready;
                    OP_CLEAR: n_pun_ready = 1'b0;
                    OP_START: begin
                        n_pun_data = i_acc_value[BYTE_W-1:0];
                        n_pun_rem  = pun_load;
                    end
                    OP_CLEAR_START: begin
                        n_pun_ready = 1'b0;
                        n_pun_data  = i_acc_value[BYTE_W-1:0];
                        n_pun_rem   = pun_load;
                    end
                    default: ;
                endcase
            end
            CMD_TICK: begin
                if (r_rdr_rem != '0) begin
                    n_rdr_rem = r_rdr_rem - TIMER_BITS'(1);
                    if (r_rdr_rem == TIMER_BITS'(1)) begin
                        n_rdr_ready = 1'b1;
                        if (i_tape_present) begin
                            n_rdr_data = i_tape_byte;
                            n_taken    = 1'b1;
                        end else begin
                            n_rdr_data = ALL_HOLES;
                        end
                    end
                end
                if (r_pun_rem != '0) begin
                    n_pun_rem = r_pun_rem - TIMER_BITS'(1);
                    if (r_pun_rem == TIMER_BITS'(1)) begin
                        n_pun_ready = 1'b1;
                        n_pvalid    = 1'b1;
                        n_pbyte     = r_pun_data;
                    end
                end
            end
            default: ;
        endcase
        n_irq = n_irq_en & (n_rdr_ready | n_pun_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rdr_ready <= 1'b0;
            r_pun_ready <= 1'b0;
            r_irq_en    <= 1'b1;
            r_rdr_data  <= '0;
            r_pun_data  <= '0;
            r_rdr_rem   <= '0;
            r_pun_rem   <= '0;
        end else if (in_acc) begin
            r_rdr_ready <= n_rdr_ready;
            r_pun_ready <= n_pun_ready;
            r_irq_en    <= n_irq_en;
            r_rdr_data  <= n_rdr_data;
            r_pun_data  <= n_pun_data;
            r_rdr_rem   <= n_rdr_rem;
            r_pun_rem   <= n_pun_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_skip   <= n_skip;
            r_orv    <= n_orv;
            r_irq    <= n_irq;
            r_pvalid <= n_pvalid;
            r_pbyte  <= n_pbyte;
            r_taken  <= n_taken;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_skip         = r_skip;
    assign o_acc_or_value = r_orv;
    assign o_irq_request  = r_irq;
    assign o_punch_valid  = r_pvalid;
    assign o_punch_byte   = r_pbyte;
    assign o_tape_taken   = r_taken;

    `PTRPC_ASSERT_NOW(a_irq_matches_state, r_out_valid, o_irq_request == (r_irq_en & (r_rdr_ready | r_pun_ready)), "irq result disagrees with flags")
    `PTRPC_ASSERT_NOW(a_punch_sets_flag, r_out_valid && o_punch_valid, r_pun_ready, "punch beat without punch flag")
    `PTRPC_ASSERT_NOW(a_tape_sets_flag, r_out_valid && o_tape_taken, r_rdr_ready, "tape taken without reader flag")
    `PTRPC_ASSERT_NEXT(a_tick_only_fields, in_acc && (t_cmd'(i_command) != CMD_TICK), !o_punch_valid && !o_tape_taken, "tick field set on instruction beat")

endmodule
